FILE: rtl/core/rsls_pkg.sv
package rsls_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FAIL_LIMIT      = 3'd0,
    CFG_STALE_LIMIT     = 3'd1,
    CFG_IDENTITY_PERIOD = 3'd2,
    CFG_EXPECTED_MODEL  = 3'd3,
    CFG_BACKOFF_MIN     = 3'd4,
    CFG_BACKOFF_MAX     = 3'd5,
    CFG_REPORT_EVERY    = 3'd6
  } cfg_idx_t;

  localparam logic [3:0]  RstFailLimit     = 4'd3;
  localparam logic [3:0]  RstStaleLimit    = 4'd4;
  localparam logic [7:0]  RstIdentityPer   = 8'd20;
  localparam logic [7:0]  RstExpectedModel = 8'hEE;
  localparam logic [15:0] RstBackoffMin    = 16'd5000;
  localparam logic [15:0] RstBackoffMax    = 16'd60000;
  localparam logic [7:0]  RstReportEvery   = 8'd10;

  localparam logic [15:0] InvalidRange = 16'hFFFF;
  localparam logic [3:0]  CountSat4    = 4'hF;
  localparam logic [7:0]  CountSat8    = 8'hFF;
  localparam logic [2:0]  NoNewResult  = 3'd0;

  // floor(x/10) == (x * Div10Mult) >> Div10Shift for every x below 2^20.
  localparam int          Div10Shift = 23;
  localparam logic [19:0] Div10Mult  = 20'd838861;

  typedef struct packed {
    logic [3:0]  fail_limit;
    logic [3:0]  stale_limit;
    logic [7:0]  identity_period;
    logic [7:0]  expected_model_id;
    logic [15:0] backoff_min_ms;
    logic [15:0] backoff_max_ms;
    logic [7:0]  report_every;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        bus_granted;
    logic        status_read_ok;
    logic [2:0]  interrupt_status;
    logic        range_read_ok;
    logic [15:0] range_mm;
    logic        clear_ok;
    logic        model_read_ok;
    logic [7:0]  model_id;
    logic        recovery_ok;
  } in_item_t;

  typedef struct packed {
    logic        healthy;
    logic        link_lost;
    logic        recovery_attempted;
    logic        sample_accepted;
    logic        report_valid;
    logic [15:0] filtered_mm;
    logic [15:0] backoff_ms;
  } out_item_t;

endpackage

FILE: rtl/core/rsls_cfg_regs.sv
module rsls_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [rsls_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [rsls_pkg::CfgDataW-1:0] cfg_wdata,
  output rsls_pkg::cfg_t               cfg
);
  import rsls_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_FAIL_LIMIT:      cfg_nxt.fail_limit        = cfg_wdata[3:0];
        CFG_STALE_LIMIT:     cfg_nxt.stale_limit       = cfg_wdata[3:0];
        CFG_IDENTITY_PERIOD: cfg_nxt.identity_period   = cfg_wdata[7:0];
        CFG_EXPECTED_MODEL:  cfg_nxt.expected_model_id = cfg_wdata[7:0];
        CFG_BACKOFF_MIN:     cfg_nxt.backoff_min_ms    = cfg_wdata;
        CFG_BACKOFF_MAX:     cfg_nxt.backoff_max_ms    = cfg_wdata;
        CFG_REPORT_EVERY:    cfg_nxt.report_every      = cfg_wdata[7:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fail_limit        <= RstFailLimit;
      cfg_r.stale_limit       <= RstStaleLimit;
      cfg_r.identity_period   <= RstIdentityPer;
      cfg_r.expected_model_id <= RstExpectedModel;
      cfg_r.backoff_min_ms    <= RstBackoffMin;
      cfg_r.backoff_max_ms    <= RstBackoffMax;
      cfg_r.report_every      <= RstReportEvery;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/rsls_avg_filter.sv
module rsls_avg_filter (
  input  logic [15:0] avg_mm,
  input  logic [15:0] sample_mm,
  output logic [15:0] avg_nxt
);
  import rsls_pkg::*;

  logic [19:0] sum;
  logic [39:0] prod;

  // The new average is floor((9*avg + sample)/10); an empty average takes the sample.
  assign sum     = {1'b0, avg_mm, 3'b000} + {4'b0000, avg_mm} + {4'b0000, sample_mm};
  assign prod    = sum * Div10Mult;
  assign avg_nxt = (avg_mm == 16'd0) ? sample_mm : prod[Div10Shift+15:Div10Shift];

endmodule

FILE: rtl/core/rsls_link_ctrl.sv
module rsls_link_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  rsls_pkg::in_item_t  item,
  input  rsls_pkg::cfg_t      cfg,
  output rsls_pkg::out_item_t result
);
  import rsls_pkg::*;

  logic        healthy_r,    healthy_nxt;
  logic [3:0]  fail_cnt_r,   fail_cnt_nxt;
  logic [3:0]  stale_cnt_r,  stale_cnt_nxt;
  logic [7:0]  ident_cnt_r,  ident_cnt_nxt;
  logic [7:0]  sample_cnt_r, sample_cnt_nxt;
  logic [15:0] avg_r,        avg_nxt;
  logic [31:0] last_rec_r,   last_rec_nxt;
  logic [15:0] retry_r,      retry_nxt;

  logic [31:0] elapsed;
  logic [16:0] retry_dbl;
  logic [15:0] avg_filt;
  logic [3:0]  fail_inc;
  logic [3:0]  stale_inc;
  logic [7:0]  ident_inc;
  logic [7:0]  sample_inc;
  logic        range_ok;
  logic        poll_ok;
  logic        lost;
  logic        attempted;
  logic        accepted;
  logic        report;

  rsls_avg_filter u_avg (
    .avg_mm    (avg_r),
    .sample_mm (item.range_mm),
    .avg_nxt   (avg_filt)
  );

  assign elapsed    = item.now_ms - last_rec_r;
  assign retry_dbl  = {retry_r, 1'b0};
  assign fail_inc   = (fail_cnt_r == CountSat4) ? fail_cnt_r : fail_cnt_r + 4'd1;
  assign stale_inc  = (stale_cnt_r == CountSat4) ? stale_cnt_r : stale_cnt_r + 4'd1;
  assign ident_inc  = (ident_cnt_r == CountSat8) ? ident_cnt_r : ident_cnt_r + 8'd1;
  assign sample_inc = sample_cnt_r + 8'd1;
  assign range_ok   = item.range_read_ok && (item.range_mm != InvalidRange) && item.clear_ok;

  always_comb begin
    healthy_nxt    = healthy_r;
    fail_cnt_nxt   = fail_cnt_r;
    stale_cnt_nxt  = stale_cnt_r;
    ident_cnt_nxt  = ident_cnt_r;
    sample_cnt_nxt = sample_cnt_r;
    avg_nxt        = avg_r;
    last_rec_nxt   = last_rec_r;
    retry_nxt      = retry_r;
    poll_ok        = 1'b0;
    lost           = 1'b0;
    attempted      = 1'b0;
    accepted       = 1'b0;
    report         = 1'b0;

    if (!healthy_r) begin
      if (elapsed >= {16'd0, retry_r}) begin
        attempted    = 1'b1;
        last_rec_nxt = item.now_ms;
        if (item.recovery_ok) begin
          healthy_nxt    = 1'b1;
          fail_cnt_nxt   = 4'd0;
          stale_cnt_nxt  = 4'd0;
          ident_cnt_nxt  = 8'd0;
          sample_cnt_nxt = 8'd0;
          avg_nxt        = 16'd0;
        end else if (retry_r == 16'd0) begin
          retry_nxt = cfg.backoff_min_ms;
        end else if (retry_dbl < {1'b0, cfg.backoff_max_ms}) begin
          retry_nxt = retry_dbl[15:0];
        end else begin
          retry_nxt = cfg.backoff_max_ms;
        end
      end
    end else begin
      if (item.bus_granted) begin
        if (!item.status_read_ok) begin
          fail_cnt_nxt = fail_inc;
        end else if (item.interrupt_status == NoNewResult) begin
          stale_cnt_nxt = stale_inc;
          if (stale_inc >= cfg.stale_limit) begin
            fail_cnt_nxt = cfg.fail_limit;
          end
        end else begin
          stale_cnt_nxt = 4'd0;
          poll_ok       = range_ok;
          if (range_ok) begin
            ident_cnt_nxt = ident_inc;
            if (ident_inc >= cfg.identity_period) begin
              ident_cnt_nxt = 8'd0;
              poll_ok = item.model_read_ok && (item.model_id == cfg.expected_model_id);
            end
          end
          fail_cnt_nxt = poll_ok ? 4'd0 : fail_inc;
        end
      end

      if (poll_ok) begin
        accepted       = 1'b1;
        avg_nxt        = avg_filt;
        sample_cnt_nxt = sample_inc;
        if ((sample_inc >= cfg.report_every) || (sample_inc == 8'd0)) begin
          sample_cnt_nxt = 8'd0;
          report         = 1'b1;
        end
      end else if (fail_cnt_nxt >= cfg.fail_limit) begin
        healthy_nxt = 1'b0;
        lost        = 1'b1;
        retry_nxt   = (elapsed > {16'd0, cfg.backoff_max_ms}) ? 16'd0 : cfg.backoff_min_ms;
      end
    end

    result.healthy            = healthy_nxt;
    result.link_lost          = lost;
    result.recovery_attempted = attempted;
    result.sample_accepted    = accepted;
    result.report_valid       = report;
    result.filtered_mm        = avg_nxt;
    result.backoff_ms         = retry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      healthy_r    <= 1'b0;
      fail_cnt_r   <= 4'd0;
      stale_cnt_r  <= 4'd0;
      ident_cnt_r  <= 8'd0;
      sample_cnt_r <= 8'd0;
      avg_r        <= 16'd0;
      last_rec_r   <= 32'd0;
      retry_r      <= 16'd0;
    end else if (step) begin
      healthy_r    <= healthy_nxt;
      fail_cnt_r   <= fail_cnt_nxt;
      stale_cnt_r  <= stale_cnt_nxt;
      ident_cnt_r  <= ident_cnt_nxt;
      sample_cnt_r <= sample_cnt_nxt;
      avg_r        <= avg_nxt;
      last_rec_r   <= last_rec_nxt;
      retry_r      <= retry_nxt;
    end
  end

endmodule

FILE: rtl/core/ranging_sensor_link_supervisor.sv
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_ready   in_data (in_item_t), one poll
// out_     output     out_valid/out_ready out_data (out_item_t), one result per poll
// cfg_     input      cfg_we              cfg_idx, cfg_wdata
//
// A poll is captured in an input register and evaluated once the output register
// can take it; the link state is updated as the result register is loaded.
// The block sustains one poll per cycle while the output is not stalled.
// A stalled output register holds the pipeline; an input transfer is still taken
// when the output register is being emptied in the same cycle.
// Synchronous reset clears the link state and loads the default register values.
module ranging_sensor_link_supervisor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rsls_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rsls_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [rsls_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [rsls_pkg::CfgDataW-1:0] cfg_wdata
);
  import rsls_pkg::*;

  cfg_t      cfg;
  in_item_t  in_r;
  logic      in_valid_r;
  out_item_t out_r;
  out_item_t result;
  logic      out_valid_r;
  logic      advance;
  logic      step;

  rsls_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rsls_link_ctrl u_link (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_r),
    .cfg    (cfg),
    .result (result)
  );

  assign advance  = !out_valid_r || out_ready;
  assign step     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (step) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
